[hw/rtl/dat_pkg.sv]
// Package: shared constants, codes and types of the double-array trie lookup.
package dat_pkg;

  // Table geometry and field widths
  localparam int TABLE_DEPTH   = 4096;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int BASE_W        = 12;
  localparam int CHECK_W       = 13;
  localparam int SYM_W         = 5;
  localparam int ALPHABET_SIZE = 26;
  localparam int ROOT_RESET    = 1;

  // Item kinds
  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SYMBOL = 1'b1
  } opcode_t;

  // Request from the walk logic to the table memories
  typedef struct packed {
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [BASE_W-1:0]         wr_base;
    logic signed [CHECK_W-1:0] wr_check;
    logic                      base_rd_en;
    logic [ADDR_W-1:0]         base_rd_addr;
    logic                      check_rd_en;
    logic [ADDR_W-1:0]         check_rd_addr;
  } mem_req_t;

endpackage

[hw/rtl/dat_if.sv]
// Interfaces: input item, result and configuration channels.
interface dat_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [dat_pkg::ADDR_W-1:0]         entry_index;
  logic [dat_pkg::BASE_W-1:0]         entry_base;
  logic signed [dat_pkg::CHECK_W-1:0] entry_check;
  logic [dat_pkg::SYM_W-1:0]          symbol;
  logic                               last;

  modport source (
    output valid, opcode, entry_index, entry_base, entry_check, symbol, last,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, entry_base, entry_check, symbol, last,
    output ready
  );
endinterface

interface dat_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink (input valid, found, output ready);
endinterface

interface dat_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dat_pkg::ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/dat_tables.sv]
// Base and check table memories with the post-reset clearing pass.
module dat_tables (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dat_pkg::mem_req_t                  req,
  output logic [dat_pkg::BASE_W-1:0]         base_rd,
  output logic signed [dat_pkg::CHECK_W-1:0] check_rd,
  output logic                               clear_busy
);

  logic [dat_pkg::BASE_W-1:0]         base_mem  [dat_pkg::TABLE_DEPTH];
  logic signed [dat_pkg::CHECK_W-1:0] check_mem [dat_pkg::TABLE_DEPTH];

  logic                       clr_busy_r;
  logic                       clr_busy_nxt;
  logic [dat_pkg::ADDR_W-1:0] clr_addr_r;
  logic [dat_pkg::ADDR_W-1:0] clr_addr_nxt;

  // Clearing sweep, one entry per cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == dat_pkg::ADDR_W'(dat_pkg::TABLE_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Base table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      base_mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      base_mem[req.wr_addr] <= req.wr_base;
    end
    if (req.base_rd_en) begin
      base_rd <= base_mem[req.base_rd_addr];
    end
  end

  // Check table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      check_mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      check_mem[req.wr_addr] <= req.wr_check;
    end
    if (req.check_rd_en) begin
      check_rd <= check_mem[req.check_rd_addr];
    end
  end

  assign clear_busy = clr_busy_r;

endmodule

[hw/rtl/double_array_trie_lookup.sv]
// Top level: double-array trie word lookup over base and check tables.
//
//  channel | dir | payload                                         | beat taken when
//  in_ch   | in  | opcode entry_index entry_base entry_check       | valid && ready
//          |     | symbol last                                     |
//  out_ch  | out | found (one beat per word, on its last symbol)   | valid && ready
//  cfg_ch  | in  | data = root_node                                | valid && ready
//
// A write beat writes both tables in the cycle it is taken. A symbol beat has two steps:
// in the cycle it is taken, base + symbol addresses both tables, and then the registered
// check word is compared; the base of the child is fetched alongside, so the walk never
// waits on a second read. After reset a clearing pass zeroes both tables, 4096 entries
// each, with in_ch held not ready. A found beat waiting on out_ch holds the next last
// symbol in its compare cycle; in_ch stays not ready until out_ch takes the waiting beat.
module double_array_trie_lookup (
  input  logic      clk,
  input  logic      rst_n,
  dat_in_if.sink    in_ch,
  dat_out_if.source out_ch,
  dat_cfg_if.sink   cfg_ch
);

  localparam int AW = dat_pkg::ADDR_W;

  // Walk state
  logic [AW-1:0]              root_r,        root_nxt;
  logic [AW-1:0]              cur_r,         cur_nxt;
  logic [dat_pkg::BASE_W-1:0] base_cur_r,    base_cur_nxt;
  logic                       rd_live_r,     rd_live_nxt;
  logic                       walk_failed_r, walk_failed_nxt;
  // Symbol in flight
  logic                       pend_r,        pend_nxt;
  logic                       pend_last_r,   pend_last_nxt;
  logic                       pend_ok_r,     pend_ok_nxt;
  logic [AW-1:0]              next_r,        next_nxt;
  // Result register
  logic                       out_valid_r,   out_valid_nxt;
  logic                       found_r,       found_nxt;

  logic [dat_pkg::BASE_W-1:0]         base_rd;
  logic signed [dat_pkg::CHECK_W-1:0] check_rd;
  logic                               clear_busy;
  dat_pkg::mem_req_t                  req;

  logic                       in_ready;
  logic                       sym_acc;
  logic                       wr_acc;
  logic [dat_pkg::BASE_W-1:0] base_cur;
  logic [AW:0]                sum;
  logic                       step_ok;
  logic                       out_free;
  logic                       done;
  logic [dat_pkg::CHECK_W-1:0] check_mag;
  logic                       match;

  dat_tables u_tables (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .base_rd    (base_rd),
    .check_rd   (check_rd),
    .clear_busy (clear_busy)
  );

  // Handshakes
  assign in_ready     = !clear_busy && !pend_r;
  assign in_ch.ready  = in_ready;
  assign sym_acc      = in_ch.valid && in_ready &&
                        (in_ch.opcode == dat_pkg::OP_SYMBOL);
  assign wr_acc       = in_ch.valid && in_ready &&
                        (in_ch.opcode == dat_pkg::OP_WRITE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign done         = pend_r && (!pend_last_r || out_free);

  // Child address: base of current node plus symbol
  assign base_cur = rd_live_r ? base_rd : base_cur_r;
  assign sum      = (AW+1)'(base_cur) + (AW+1)'(in_ch.symbol);
  assign step_ok  = !walk_failed_r && !sum[AW] &&
                    (in_ch.symbol < dat_pkg::SYM_W'(dat_pkg::ALPHABET_SIZE));

  // Parent check on the fetched check word
  assign check_mag = check_rd[dat_pkg::CHECK_W-1] ? 13'(-check_rd) : 13'(check_rd);
  assign match     = pend_ok_r && (check_mag == {1'b0, cur_r});

  // Table requests
  always_comb begin
    req.wr_en         = wr_acc;
    req.wr_addr       = in_ch.entry_index;
    req.wr_base       = in_ch.entry_base;
    req.wr_check      = in_ch.entry_check;
    req.base_rd_en    = sym_acc || (done && pend_last_r);
    req.base_rd_addr  = sym_acc ? sum[AW-1:0] : root_r;
    req.check_rd_en   = sym_acc;
    req.check_rd_addr = sum[AW-1:0];
  end

  // Next-state logic
  always_comb begin
    root_nxt        = root_r;
    cur_nxt         = cur_r;
    base_cur_nxt    = base_cur_r;
    rd_live_nxt     = 1'b0;
    walk_failed_nxt = walk_failed_r;
    pend_nxt        = pend_r;
    pend_last_nxt   = pend_last_r;
    pend_ok_nxt     = pend_ok_r;
    next_nxt        = next_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    found_nxt       = found_r;

    if (cfg_ch.valid) begin
      root_nxt = cfg_ch.data;
    end

    // capture the freshly read root base
    if (rd_live_r) begin
      base_cur_nxt = base_rd;
    end
    // a table write to the current node refreshes its cached base
    if (wr_acc && (in_ch.entry_index == cur_r)) begin
      base_cur_nxt = in_ch.entry_base;
    end

    if (sym_acc) begin
      pend_nxt      = 1'b1;
      pend_last_nxt = in_ch.last;
      pend_ok_nxt   = step_ok;
      next_nxt      = sum[AW-1:0];
    end

    if (done) begin
      pend_nxt = 1'b0;
      if (pend_last_r) begin
        out_valid_nxt   = 1'b1;
        found_nxt       = match && check_rd[dat_pkg::CHECK_W-1];
        cur_nxt         = root_r;
        walk_failed_nxt = 1'b0;
        rd_live_nxt     = 1'b1;
      end else if (match) begin
        cur_nxt      = next_r;
        base_cur_nxt = base_rd;
      end else begin
        walk_failed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r        <= AW'(dat_pkg::ROOT_RESET);
      cur_r         <= AW'(dat_pkg::ROOT_RESET);
      base_cur_r    <= '0;
      rd_live_r     <= 1'b0;
      walk_failed_r <= 1'b0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      root_r        <= root_nxt;
      cur_r         <= cur_nxt;
      base_cur_r    <= base_cur_nxt;
      rd_live_r     <= rd_live_nxt;
      walk_failed_r <= walk_failed_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload of the symbol in flight and the result
  always_ff @(posedge clk) begin
    pend_last_r <= pend_last_nxt;
    pend_ok_r   <= pend_ok_nxt;
    next_r      <= next_nxt;
    found_r     <= found_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.found = found_r;

  // Checks
  a_sym_pends: assert property (@(posedge clk) disable iff (!rst_n)
    sym_acc |=> pend_r)
    else $error("symbol taken without a pending step");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (done && pend_last_r) |=> (out_valid_r && rd_live_r && !walk_failed_r))
    else $error("word end did not post a result and reload the root");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_ch.ready)
    else $error("input taken during clearing pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> ($stable(found_r) && out_valid_r))
    else $error("waiting result overwritten");

  a_fail_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !pend_last_r && !match) |=> $stable(cur_r))
    else $error("failed step moved the current node");

endmodule
